// ----- hdl/rtpm_pkg.sv -----
// Shared types, constants and lookup tables for the patterned mono packer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package rtpm_pkg;

	localparam int NUM_PATTERN_ENTRIES = 6;
	localparam int ENTRY_REG_COUNT     = 6;
	localparam int STRIPE_PERIOD       = 6;
	localparam int DOT_PERIOD          = 8;
	localparam int WIDEN_STEPS         = 8;

	localparam int STRIPE_W   = (STRIPE_PERIOD > 1) ? $clog2(STRIPE_PERIOD) : 1;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 28;

	// Register indexes on the configuration port.
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_0    = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_1    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_2    = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_3    = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_4    = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_5    = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_DARK_LIMIT = REG_IDX_W'(ENTRY_REG_COUNT);

	localparam logic [9:0] DARK_LIMIT_RESET = 10'd719;

	// Fill pattern codes.
	localparam logic [2:0] PAT_OFF      = 3'd0;
	localparam logic [2:0] PAT_VERT     = 3'd1;
	localparam logic [2:0] PAT_HORIZ    = 3'd2;
	localparam logic [2:0] PAT_RSL      = 3'd3;
	localparam logic [2:0] PAT_LSL      = 3'd4;
	localparam logic [2:0] PAT_SOLID    = 3'd5;
	localparam logic [2:0] PAT_DOTS     = 3'd6;
	localparam logic [2:0] PAT_RESERVED = 3'd7;

	typedef struct packed {
		logic        widen;
		logic [2:0]  code;
		logic [23:0] colour;
	} entry_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] pixel_column;
		logic [11:0] pixel_row;
		logic        row_end;
	} in_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       row_done;
	} out_t;

	// One classified pixel handed from the classifier to the packer.
	typedef struct packed {
		logic valid;
		logic white;
		logic row_end;
	} mono_t;

	typedef logic [255:0][STRIPE_W-1:0] lo_tab_t;
	typedef logic [15:0][STRIPE_W-1:0]  hi_tab_t;

	function automatic lo_tab_t build_stripe_lo();
		lo_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = STRIPE_W'(i % STRIPE_PERIOD);
		end
		return t;
	endfunction

	function automatic hi_tab_t build_stripe_hi();
		hi_tab_t t;
		for (int i = 0; i < 16; i++) begin
			t[i] = STRIPE_W'((i * 256) % STRIPE_PERIOD);
		end
		return t;
	endfunction

	localparam lo_tab_t STRIPE_LO = build_stripe_lo();
	localparam hi_tab_t STRIPE_HI = build_stripe_hi();

	// Residue of a 12-bit coordinate modulo the stripe period: the low byte and the
	// high nibble are reduced by table, and their sum needs one correction at most.
	function automatic logic [STRIPE_W-1:0] stripe_mod(input logic [11:0] x);
		logic [STRIPE_W:0] s;
		s = {1'b0, STRIPE_LO[x[7:0]]} + {1'b0, STRIPE_HI[x[11:8]]};
		if (s >= (STRIPE_W+1)'(STRIPE_PERIOD)) begin
			s = s - (STRIPE_W+1)'(STRIPE_PERIOD);
		end
		return s[STRIPE_W-1:0];
	endfunction

endpackage

// ----- hdl/rtpm_classify.sv -----
// Pixel classifier: colour matching against the pattern entries, fill patterns
// and the dark threshold, all combinational. Depends on rtpm_pkg.
module rtpm_classify (
	input  logic                                               valid,
	input  rtpm_pkg::in_t                                      pixel,
	input  rtpm_pkg::entry_t [rtpm_pkg::ENTRY_REG_COUNT-1:0]   entries,
	input  logic [9:0]                                         dark_limit,
	output rtpm_pkg::mono_t                                    mono
);

	localparam logic [rtpm_pkg::STRIPE_W-1:0] STRIPE_LAST =
		rtpm_pkg::STRIPE_W'(rtpm_pkg::STRIPE_PERIOD - 1);

	logic [23:0]                   pix;
	logic [9:0]                    rgb_sum;
	logic [rtpm_pkg::STRIPE_W-1:0] col_m, row_m, sum_m, dif_m;
	logic [rtpm_pkg::STRIPE_W:0]   sum_w, dif_w;
	logic                          dot_hit;
	logic                          white;

	logic [rtpm_pkg::NUM_PATTERN_ENTRIES-1:0] hit;
	logic [rtpm_pkg::NUM_PATTERN_ENTRIES-1:0] pat_white;

	assign pix     = {pixel.red, pixel.green, pixel.blue};
	assign rgb_sum = 10'(pixel.red) + 10'(pixel.green) + 10'(pixel.blue);

	assign col_m = rtpm_pkg::stripe_mod(pixel.pixel_column);
	assign row_m = rtpm_pkg::stripe_mod(pixel.pixel_row);

	// Sum and difference residues are rebuilt from the two coordinate residues;
	// the difference is wrapped into the non-negative range.
	always_comb begin
		sum_w = {1'b0, col_m} + {1'b0, row_m};
		if (sum_w >= (rtpm_pkg::STRIPE_W+1)'(rtpm_pkg::STRIPE_PERIOD)) begin
			sum_w = sum_w - (rtpm_pkg::STRIPE_W+1)'(rtpm_pkg::STRIPE_PERIOD);
		end
		if (col_m >= row_m) begin
			dif_w = {1'b0, col_m} - {1'b0, row_m};
		end else begin
			dif_w = {1'b0, col_m} + (rtpm_pkg::STRIPE_W+1)'(rtpm_pkg::STRIPE_PERIOD)
				- {1'b0, row_m};
		end
	end

	assign sum_m = sum_w[rtpm_pkg::STRIPE_W-1:0];
	assign dif_m = dif_w[rtpm_pkg::STRIPE_W-1:0];

	assign dot_hit = ((pixel.pixel_column % rtpm_pkg::DOT_PERIOD) == 0)
		&& ((pixel.pixel_row % rtpm_pkg::DOT_PERIOD) == 0);

	for (genvar i = 0; i < rtpm_pkg::NUM_PATTERN_ENTRIES; i++) begin : g_entry
		logic [24:0] diff;
		logic [23:0] mag;
		logic        grey_hit;

		assign diff = {1'b0, pix} - {1'b0, entries[i].colour};
		assign mag  = diff[24] ? (24'(~diff[23:0]) + 24'd1) : diff[23:0];

		// A multiple k of the grey step with a small k has three equal bytes, all k.
		assign grey_hit = entries[i].widen
			&& (mag[23:16] == mag[15:8]) && (mag[15:8] == mag[7:0])
			&& (mag[7:0] <= 8'(rtpm_pkg::WIDEN_STEPS));

		always_comb begin
			hit[i] = 1'b0;
			if (entries[i].code != rtpm_pkg::PAT_OFF
					&& entries[i].code != rtpm_pkg::PAT_RESERVED) begin
				hit[i] = (mag == 24'd0) || grey_hit;
			end
		end

		always_comb begin
			case (entries[i].code)
				rtpm_pkg::PAT_VERT:  pat_white[i] = (col_m != STRIPE_LAST);
				rtpm_pkg::PAT_HORIZ: pat_white[i] = (row_m != STRIPE_LAST);
				rtpm_pkg::PAT_RSL:   pat_white[i] = (sum_m != STRIPE_LAST);
				rtpm_pkg::PAT_LSL:   pat_white[i] = (dif_m != STRIPE_LAST);
				rtpm_pkg::PAT_SOLID: pat_white[i] = 1'b0;
				rtpm_pkg::PAT_DOTS:  pat_white[i] = !dot_hit;
				default:             pat_white[i] = 1'b1;
			endcase
		end
	end

	// Higher entries are visited later and so take priority.
	always_comb begin
		white = (rgb_sum >= dark_limit);
		for (int i = 0; i < rtpm_pkg::NUM_PATTERN_ENTRIES; i++) begin
			if (hit[i]) begin
				white = pat_white[i];
			end
		end
	end

	assign mono.valid   = valid;
	assign mono.white   = white;
	assign mono.row_end = pixel.row_end;

endmodule

// ----- hdl/rtpm_packer.sv -----
// Bit packer: gathers mono pixels MSB first into a byte and holds finished bytes
// in the output register. Depends on rtpm_pkg.
module rtpm_packer (
	input  logic            clk,
	input  logic            arst_n,
	input  rtpm_pkg::mono_t mono,
	output logic            take,
	output logic            out_valid,
	input  logic            out_ready,
	output rtpm_pkg::out_t  out_data
);

	logic [7:0]     acc_q;
	logic [2:0]     pos_q;
	logic           out_valid_q;
	rtpm_pkg::out_t out_data_q;

	logic [7:0] acc_next;
	logic       emit;

	assign acc_next = acc_q | (8'(mono.white) << (3'd7 - pos_q));
	assign emit     = (pos_q == 3'd7) || mono.row_end;

	// A pixel that completes no byte never waits on the output side.
	assign take = mono.valid && (!emit || !out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && emit) begin
				acc_q       <= '0;
				pos_q       <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (take) begin
					acc_q <= acc_next;
					pos_q <= pos_q + 3'd1;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_data_q.packed_byte <= acc_next;
			out_data_q.row_done    <= mono.row_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- hdl/rgb_to_patterned_mono_packer_core.sv -----
// A pixel passes the input register; the byte it completes is held in the packer's output register.
// Throughput: one pixel per cycle; only a completing pixel waits on a full output register.
// Reset clears the pattern entries, sets the dark limit to 719 and empties the packer.
// Top level: configuration registers, input register, classifier and packer.
// Depends on rtpm_pkg, rtpm_classify and rtpm_packer.
module rgb_to_patterned_mono_packer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [rtpm_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [rtpm_pkg::CFG_DATA_W-1:0]     wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rtpm_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rtpm_pkg::out_t                      out_data
);

	rtpm_pkg::entry_t [rtpm_pkg::ENTRY_REG_COUNT-1:0] entries_q;
	logic [9:0]                                       dark_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q    <= '0;
			dark_limit_q <= rtpm_pkg::DARK_LIMIT_RESET;
		end else if (wr_en) begin
			if (wr_index < rtpm_pkg::REG_DARK_LIMIT) begin
				entries_q[wr_index] <= wr_data;
			end else if (wr_index == rtpm_pkg::REG_DARK_LIMIT) begin
				dark_limit_q <= wr_data[9:0];
			end
		end
	end

	rtpm_pkg::in_t   pixel_s1;
	logic            valid_s1;
	logic            take;
	rtpm_pkg::mono_t mono;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_s1 <= in_data;
		end
	end

	rtpm_classify u_classify (
		.valid      (valid_s1),
		.pixel      (pixel_s1),
		.entries    (entries_q),
		.dark_limit (dark_limit_q),
		.mono       (mono)
	);

	rtpm_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.mono      (mono),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
